// ===== src/lpot_pkg.sv =====
// Shared field widths, operation codes and status codes of the LRU page order tracker.
`default_nettype none

package lpot_pkg;

  localparam int FUNC_W = 2;
  localparam int PROC_W = 8;
  localparam int PAGE_W = 16;
  localparam int STAT_W = 2;

  typedef logic [FUNC_W-1:0] func_t;
  typedef logic [STAT_W-1:0] status_t;

  localparam func_t FUNC_TOUCH  = 2'd0;
  localparam func_t FUNC_INSERT = 2'd1;
  localparam func_t FUNC_EVICT  = 2'd2;

  localparam status_t ST_OK      = 2'd0;
  localparam status_t ST_NOMATCH = 2'd1;
  localparam status_t ST_EMPTY   = 2'd2;
  localparam status_t ST_FULL    = 2'd3;

endpackage

`default_nettype wire

// ===== src/lpot_req_if.sv =====
// Request channel of the LRU page order tracker: operation and page tags.
`default_nettype none

interface lpot_req_if import lpot_pkg::*; ();
  logic                valid;
  logic                ready;
  func_t               func;
  logic [PROC_W-1:0]   process_number;
  logic [PAGE_W-1:0]   page_number;

  modport source (output valid, output func, output process_number, output page_number,
                  input ready);
  modport sink   (input valid, input func, input process_number, input page_number,
                  output ready);
endinterface

`default_nettype wire

// ===== src/lpot_rsp_if.sv =====
// Response channel of the LRU page order tracker: status and evicted tags.
`default_nettype none

interface lpot_rsp_if import lpot_pkg::*; ();
  logic                valid;
  logic                ready;
  status_t             status;
  logic [PROC_W-1:0]   victim_process;
  logic [PAGE_W-1:0]   victim_page;

  modport source (output valid, output status, output victim_process, output victim_page,
                  input ready);
  modport sink   (input valid, input status, input victim_process, input victim_page,
                  output ready);
endinterface

`default_nettype wire

// ===== src/lpot_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module lpot_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== src/lru_page_order_tracker.sv =====
// Top level of the LRU page order tracker: sequencer, entry RAM and response register.
// A touch compares slots from the front; a hit behind the front shifts the newer
// entries down a slot and writes the tag to the front. An insert shifts all entries down
// and writes slot 0; an evict reads the back slot. Empty/full/unused cases leave the RAM alone.
// One request at a time; a new request is taken the cycle after its response loads.
// Reset (synchronous, rst high) empties the list and drops any pending response.
`default_nettype none

module lru_page_order_tracker import lpot_pkg::*; #(
  parameter int ENTRIES      = 16,
  parameter int PAGE_BITS    = 16,
  parameter int PROCESS_BITS = 8
) (
  input wire logic    clk,
  input wire logic    rst,
  lpot_req_if.sink    req,
  lpot_rsp_if.source  rsp
);

  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int OCC_W   = $clog2(ENTRIES + 1);
  localparam int ENTRY_W = PROCESS_BITS + PAGE_BITS;

  // Sequencer states
  localparam logic [3:0] S_IDLE       = 4'd0;
  localparam logic [3:0] S_SCAN_RD    = 4'd1;
  localparam logic [3:0] S_SCAN_CMP   = 4'd2;
  localparam logic [3:0] S_SHIFT_RD   = 4'd3;
  localparam logic [3:0] S_SHIFT_WR   = 4'd4;
  localparam logic [3:0] S_FRONT_WR   = 4'd5;
  localparam logic [3:0] S_EVICT_RD   = 4'd6;
  localparam logic [3:0] S_EVICT_DATA = 4'd7;
  localparam logic [3:0] S_RESP       = 4'd8;

  logic [3:0]         state, state_next;
  logic [OCC_W-1:0]   occ, occ_next;
  logic [IDX_W-1:0]   idx, idx_next;
  logic [ENTRY_W-1:0] key, key_next;       // tags being searched for or inserted
  logic               is_insert, is_insert_next;
  status_t            status_r, status_next;
  logic [PROC_W-1:0]  vproc, vproc_next;
  logic [PAGE_W-1:0]  vpage, vpage_next;

  logic               rsp_valid;
  status_t            rsp_status;
  logic [PROC_W-1:0]  rsp_vproc;
  logic [PAGE_W-1:0]  rsp_vpage;

  // Entry RAM: slot 0 holds the most recent entry
  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [IDX_W-1:0]   ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;

  logic [ENTRY_W-1:0] req_key;
  logic               req_fire;
  logic               rsp_free;
  logic               scan_last;
  logic               key_hit;

  lpot_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign req_key  = {PROCESS_BITS'(req.process_number), PAGE_BITS'(req.page_number)};
  assign req.ready = (state == S_IDLE);
  assign req_fire = req.valid && req.ready;
  assign rsp_free = !rsp_valid || rsp.ready;

  // The one comparator, shared over every slot of a touch scan
  assign key_hit   = (ram_rdata == key);
  assign scan_last = ((OCC_W'(idx) + OCC_W'(1)) == occ);

  // Shifting reads the slot above the one being written
  assign ram_raddr = (state == S_SHIFT_RD) ? (idx - IDX_W'(1)) : idx;

  always_comb begin
    state_next     = state;
    occ_next       = occ;
    idx_next       = idx;
    key_next       = key;
    is_insert_next = is_insert;
    status_next    = status_r;
    vproc_next     = vproc;
    vpage_next     = vpage;
    ram_we         = 1'b0;
    ram_waddr      = idx;
    ram_wdata      = ram_rdata;

    case (state)
      S_IDLE: begin
        if (req_fire) begin
          key_next       = req_key;
          is_insert_next = (req.func == FUNC_INSERT);
          status_next    = ST_OK;
          vproc_next     = '0;
          vpage_next     = '0;
          case (req.func)
            FUNC_TOUCH: begin
              if (occ == '0) begin
                status_next = ST_NOMATCH;
                state_next  = S_RESP;
              end else begin
                idx_next   = '0;
                state_next = S_SCAN_RD;
              end
            end
            FUNC_INSERT: begin
              if (occ == OCC_W'(ENTRIES)) begin
                status_next = ST_FULL;
                state_next  = S_RESP;
              end else if (occ == '0) begin
                state_next = S_FRONT_WR;
              end else begin
                idx_next   = occ[IDX_W-1:0];
                state_next = S_SHIFT_RD;
              end
            end
            FUNC_EVICT: begin
              if (occ == '0) begin
                status_next = ST_EMPTY;
                state_next  = S_RESP;
              end else begin
                idx_next   = occ[IDX_W-1:0] - IDX_W'(1);
                state_next = S_EVICT_RD;
              end
            end
            default: begin
              state_next = S_RESP;
            end
          endcase
        end
      end
      S_SCAN_RD: begin
        state_next = S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        if (key_hit) begin
          // A hit at the front leaves the order as it is
          state_next = (idx == '0) ? S_RESP : S_SHIFT_RD;
        end else if (scan_last) begin
          status_next = ST_NOMATCH;
          state_next  = S_RESP;
        end else begin
          idx_next   = idx + IDX_W'(1);
          state_next = S_SCAN_RD;
        end
      end
      S_SHIFT_RD: begin
        state_next = S_SHIFT_WR;
      end
      S_SHIFT_WR: begin
        ram_we     = 1'b1;
        ram_waddr  = idx;
        ram_wdata  = ram_rdata;
        idx_next   = idx - IDX_W'(1);
        state_next = (idx == IDX_W'(1)) ? S_FRONT_WR : S_SHIFT_RD;
      end
      S_FRONT_WR: begin
        ram_we     = 1'b1;
        ram_waddr  = '0;
        ram_wdata  = key;
        if (is_insert) begin
          occ_next = occ + OCC_W'(1);
        end
        state_next = S_RESP;
      end
      S_EVICT_RD: begin
        state_next = S_EVICT_DATA;
      end
      S_EVICT_DATA: begin
        vproc_next = PROC_W'(ram_rdata[ENTRY_W-1:PAGE_BITS]);
        vpage_next = PAGE_W'(ram_rdata[PAGE_BITS-1:0]);
        occ_next   = occ - OCC_W'(1);
        state_next = S_RESP;
      end
      S_RESP: begin
        // Hold until the output register is free
        if (rsp_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      occ       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      occ   <= occ_next;
      if (state == S_RESP && rsp_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx       <= idx_next;
    key       <= key_next;
    is_insert <= is_insert_next;
    status_r  <= status_next;
    vproc     <= vproc_next;
    vpage     <= vpage_next;
    if (state == S_RESP && rsp_free) begin
      rsp_status <= status_r;
      rsp_vproc  <= vproc;
      rsp_vpage  <= vpage;
    end
  end

  assign rsp.valid          = rsp_valid;
  assign rsp.status         = rsp_status;
  assign rsp.victim_process = rsp_vproc;
  assign rsp.victim_page    = rsp_vpage;

  // Occupancy never passes capacity
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= OCC_W'(ENTRIES))
    else $error("occupancy above capacity");

  // A shift step never writes the front slot
  a_shift_addr: assert property (@(posedge clk) disable iff (rst)
    state == S_SHIFT_WR |-> idx != '0)
    else $error("shift wrote slot zero");

  // Leaving the response state always presents a result
  a_resp_load: assert property (@(posedge clk) disable iff (rst)
    state == S_RESP && rsp_free |=> rsp_valid && state == S_IDLE)
    else $error("response not loaded");

  // Victim tags are zero on every response whose status is not ok
  a_victim_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status != ST_OK |-> rsp_vproc == '0 && rsp_vpage == '0)
    else $error("victim tags on a failed request");

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
// Self-checking testbench for the LRU page order tracker.
`timescale 1ns / 1ps

module testbench;
  import lpot_pkg::*;

  localparam int ENTRIES        = 16;
  localparam int PAGE_BITS      = 16;
  localparam int PROCESS_BITS   = 8;
  localparam int HALF_PERIOD    = 10;
  localparam int RESET_CYCLES   = 4;
  // The slowest response is a touch hit at the back of a full list.
  localparam int TAIL_CYCLES    = 80;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES    = 300;
  localparam int RANDOM_ITEMS   = 540;

  // Code that the block does not decode; it answers ok and leaves the list alone.
  localparam func_t FUNC_UNUSED = 2'd3;

  typedef struct packed {
    status_t           status;
    logic [PROC_W-1:0] victim_process;
    logic [PAGE_W-1:0] victim_page;
  } page_result_t;

  logic clk;
  logic rst;

  lpot_req_if req ();
  lpot_rsp_if rsp ();

  lru_page_order_tracker #(
    .ENTRIES      (ENTRIES),
    .PAGE_BITS    (PAGE_BITS),
    .PROCESS_BITS (PROCESS_BITS)
  ) uut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  // Predicted list, most recent entry in slot 0.
  logic [PROC_W-1:0] resident_proc [ENTRIES];
  logic [PAGE_W-1:0] resident_page [ENTRIES];
  int                resident_count;

  page_result_t pending_results [$];
  int           error_count;
  int           src_idle_pct;
  int           sink_idle_pct;
  int           hold_left;
  int           quiet_cycles;

  always #HALF_PERIOD clk = ~clk;

  // Move the entry at pos to the front; shift the more recent ones down by one.
  function automatic void promote(int pos);
    logic [PROC_W-1:0] p;
    logic [PAGE_W-1:0] g;
    p = resident_proc[pos];
    g = resident_page[pos];
    for (int i = pos; i > 0; i--) begin
      resident_proc[i] = resident_proc[i-1];
      resident_page[i] = resident_page[i-1];
    end
    resident_proc[0] = p;
    resident_page[0] = g;
  endfunction

  // Apply one request to the predicted list and return the response it must give.
  function automatic page_result_t apply_page_op(func_t f, logic [PROC_W-1:0] p,
                                                 logic [PAGE_W-1:0] g);
    page_result_t r;
    int           pos;
    r = '0;
    r.status = ST_OK;
    pos = -1;
    case (f)
      FUNC_TOUCH: begin
        // The first match from the front wins, so a duplicate resolves to its newest copy.
        for (int i = 0; i < resident_count; i++)
          if (pos < 0 && resident_proc[i] == p && resident_page[i] == g) pos = i;
        if (pos < 0) r.status = ST_NOMATCH;
        else promote(pos);
      end
      FUNC_INSERT: begin
        if (resident_count >= ENTRIES) begin
          r.status = ST_FULL;
        end else begin
          resident_proc[resident_count] = p;
          resident_page[resident_count] = g;
          promote(resident_count);
          resident_count++;
        end
      end
      FUNC_EVICT: begin
        if (resident_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          resident_count--;
          r.victim_process = resident_proc[resident_count];
          r.victim_page    = resident_page[resident_count];
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Offer one request from the falling edge, idling at random first, and hold it until
  // accepted. The expected response is queued at the edge that accepts the request.
  task automatic issue_request(func_t f, logic [PROC_W-1:0] p, logic [PAGE_W-1:0] g);
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      req.valid          <= 1'b0;
      req.func           <= func_t'($urandom);
      req.process_number <= PROC_W'($urandom);
      req.page_number    <= PAGE_W'($urandom);
      @(negedge clk);
    end
    req.valid          <= 1'b1;
    req.func           <= f;
    req.process_number <= p;
    req.page_number    <= g;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    pending_results.push_back(apply_page_op(f, p, g));
  endtask

  // Drop valid and hold the sender until every queued response has come back.
  task automatic wait_for_results();
    @(negedge clk);
    req.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_empty_list();
    issue_request(FUNC_EVICT, '0, '0);
    issue_request(FUNC_TOUCH, '1, '1);
  endtask

  task automatic test_unused_code();
    issue_request(FUNC_UNUSED, '1, '1);
  endtask

  // Fill to capacity with extreme tags and one duplicate, then insert once more.
  task automatic test_fill_to_capacity();
    issue_request(FUNC_INSERT, '0, '0);
    issue_request(FUNC_INSERT, '1, '1);
    issue_request(FUNC_INSERT, '0, '0);
    for (int i = 3; i < ENTRIES; i++)
      issue_request(FUNC_INSERT, PROC_W'(i * 37), PAGE_W'(i * 4099));
    issue_request(FUNC_INSERT, 8'h55, 16'haaaa);
  endtask

  // Touch the newest duplicate, the front, a deeper entry and a miss, then evict from the back.
  task automatic test_touch_order();
    issue_request(FUNC_TOUCH, '0, '0);
    issue_request(FUNC_TOUCH, '0, '0);
    issue_request(FUNC_TOUCH, '1, '1);
    issue_request(FUNC_TOUCH, '1, '0);
    issue_request(FUNC_EVICT, '0, '0);
    issue_request(FUNC_EVICT, '1, '1);
  endtask

  // Hold off the response side for a long stretch while requests keep coming.
  task automatic test_stalled_output();
    hold_left = HOLD_CYCLES;
    for (int i = 0; i < 8; i++)
      issue_request((i % 2) ? FUNC_TOUCH : FUNC_INSERT, PROC_W'(i / 2), PAGE_W'(i / 2));
  endtask

  // Let the block go fully idle between bursts of requests.
  task automatic test_pause_for_drain();
    for (int burst = 0; burst < 3; burst++) begin
      issue_request(FUNC_INSERT, PROC_W'($urandom), PAGE_W'($urandom));
      issue_request(FUNC_EVICT, '0, '0);
      wait_for_results();
    end
  endtask

  // Mostly well-formed traffic: touches of resident pages, inserts from a small tag pool
  // so duplicates and misses recur, and evicts. The insert/evict balance drifts so the
  // list swings between empty and full.
  task automatic test_random_traffic(int items);
    int                roll;
    int                insert_pct;
    int                idx;
    logic [PROC_W-1:0] p;
    logic [PAGE_W-1:0] g;
    insert_pct = 50;
    for (int n = 0; n < items; n++) begin
      if (n % 48 == 0) insert_pct = $urandom_range(20, 80);
      if ($urandom_range(1)) begin
        p = PROC_W'($urandom_range(3));
        g = PAGE_W'($urandom_range(7));
      end else begin
        p = PROC_W'($urandom);
        g = PAGE_W'($urandom);
      end
      roll = $urandom_range(99);
      if (roll < 4) begin
        issue_request(FUNC_UNUSED, p, g);
      end else if (roll < 50) begin
        if (resident_count > 0 && $urandom_range(9) < 7) begin
          idx = $urandom_range(resident_count - 1);
          p = resident_proc[idx];
          g = resident_page[idx];
        end
        issue_request(FUNC_TOUCH, p, g);
      end else if ($urandom_range(99) < insert_pct) begin
        issue_request(FUNC_INSERT, p, g);
      end else begin
        issue_request(FUNC_EVICT, p, g);
      end
    end
  endtask

  // Response side: stall at random from the falling edge, or hold off while a stretch runs.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      rsp.ready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      rsp.ready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // Compare each accepted response with the oldest expectation.
  always @(posedge clk) begin
    page_result_t want;
    if (!rst && rsp.valid && rsp.ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected response: status %0d victim %0h/%0h",
               rsp.status, rsp.victim_process, rsp.victim_page);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (rsp.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, rsp.status);
          error_count++;
        end
        if (rsp.victim_process !== want.victim_process) begin
          $error("victim_process: expected %0h, got %0h",
                 want.victim_process, rsp.victim_process);
          error_count++;
        end
        if (rsp.victim_page !== want.victim_page) begin
          $error("victim_page: expected %0h, got %0h", want.victim_page, rsp.victim_page);
          error_count++;
        end
      end
    end
  end

  // Count cycles in which neither channel moves a request or response.
  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    clk                = 1'b0;
    rst                = 1'b1;
    req.valid          = 1'b0;
    req.func           = FUNC_TOUCH;
    req.process_number = '0;
    req.page_number    = '0;
    rsp.ready          = 1'b0;
    resident_count     = 0;
    error_count        = 0;
    hold_left          = 0;
    quiet_cycles       = 0;
    src_idle_pct       = 0;
    sink_idle_pct      = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed checks with moderate idling on both sides.
    src_idle_pct  = 20;
    sink_idle_pct = 20;
    test_empty_list();
    test_unused_code();
    test_fill_to_capacity();
    test_touch_order();
    wait_for_results();

    test_stalled_output();
    wait_for_results();
    test_pause_for_drain();

    // Random traffic: receiver idles more, then the sender, then neither.
    src_idle_pct  = 38;
    sink_idle_pct = 70;
    test_random_traffic(RANDOM_ITEMS);
    wait_for_results();
    src_idle_pct  = 70;
    sink_idle_pct = 38;
    test_random_traffic(RANDOM_ITEMS);
    wait_for_results();
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    test_random_traffic(RANDOM_ITEMS);
    wait_for_results();

    // Allow any stray response time to surface before the verdict.
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== lru_page_order_tracker.f =====
src/lpot_pkg.sv
src/lpot_req_if.sv
src/lpot_rsp_if.sv
src/lpot_ram.sv
src/lru_page_order_tracker.sv
dv/testbench.sv
